/* design/rmf_pkg.sv */
// Shared types and constants for the RGB median filter.
// No dependencies; used by every design file.
package rmf_pkg;

  localparam int DEF_MAX_WIDTH  = 1024;
  localparam int DEF_MAX_RADIUS = 3;

  localparam int CFG_W   = 11;   // widest register
  localparam int IDX_W   = 2;
  localparam int HGT_W   = 11;   // image_height field width
  localparam int KOFF_W  = 4;    // signed window offset, -3..3

  localparam logic [IDX_W-1:0] REG_RADIUS = 2'd0;
  localparam logic [IDX_W-1:0] REG_WIDTH  = 2'd1;
  localparam logic [IDX_W-1:0] REG_HEIGHT = 2'd2;

  localparam logic [1:0]       RADIUS_RST = 2'd1;
  localparam logic [CFG_W-1:0] WIDTH_RST  = 11'd640;
  localparam logic [CFG_W-1:0] HEIGHT_RST = 11'd480;

  localparam logic OP_PIXEL = 1'b0;
  localparam logic OP_FLUSH = 1'b1;

  // Sort keys: low pads sort below all data, empty cells above.
  localparam logic [1:0] CLS_LOW   = 2'd0;
  localparam logic [1:0] CLS_DATA  = 2'd1;
  localparam logic [1:0] CLS_EMPTY = 2'd2;

  typedef struct packed {
    logic [1:0] cls;
    logic [7:0] val;
  } key_t;

  localparam key_t KEY_LOW   = '{cls: CLS_LOW,   val: 8'd0};
  localparam key_t KEY_EMPTY = '{cls: CLS_EMPTY, val: 8'd0};

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pixel_t;

endpackage

/* design/rmf_line_store.sv */
// Pixel ring buffer: one write port, one registered read port.
// Depends on rmf_pkg.
module rmf_line_store #(
  parameter int DEPTH = 6151,
  parameter int AW    = 13
) (
  input  logic                  clk,
  input  logic                  wr_en,
  input  logic [AW-1:0]         wr_addr,
  input  rmf_pkg::pixel_t       wr_data,
  input  logic [AW-1:0]         rd_addr,
  output rmf_pkg::pixel_t       rd_data
);

  rmf_pkg::pixel_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

/* design/rmf_sort_cell.sv */
// One cell of the insertion sort chain; holds one key.
// Depends on rmf_pkg.
module rmf_sort_cell (
  input  logic          clk,
  input  logic          init,
  input  rmf_pkg::key_t init_key,
  input  logic          insert,
  input  rmf_pkg::key_t new_key,
  input  rmf_pkg::key_t prev_key,
  input  logic          prev_gt,
  output rmf_pkg::key_t key,
  output logic          gt
);

  assign gt = (key > new_key);

  // Larger keys move one cell up; the first larger one takes the new key.
  always_ff @(posedge clk) begin
    if (init) begin
      key <= init_key;
    end else if (insert) begin
      if (prev_gt) begin
        key <= prev_key;
      end else if (gt) begin
        key <= new_key;
      end
    end
  end

endmodule

/* design/rmf_sort_chain.sv */
// Row of sort cells for one color channel, with median taps.
// Depends on rmf_pkg and rmf_sort_cell.
module rmf_sort_chain #(
  parameter int CELLS = 49,
  parameter int NW    = 6
) (
  input  logic          clk,
  input  logic          init,
  input  logic [NW-1:0] pad_low,
  input  logic          insert,
  input  logic [7:0]    value,
  input  logic          n_even,
  output logic [7:0]    median
);

  localparam int MID = (CELLS - 1) / 2;

  rmf_pkg::key_t keys [CELLS];
  logic          gts  [CELLS];
  rmf_pkg::key_t new_key;
  logic [8:0]    pair_sum;

  assign new_key = '{cls: rmf_pkg::CLS_DATA, val: value};

  for (genvar i = 0; i < CELLS; i++) begin : g_cell
    rmf_pkg::key_t init_key;
    rmf_pkg::key_t prev_key;
    logic          prev_gt;

    assign init_key = (i < int'(pad_low)) ? rmf_pkg::KEY_LOW : rmf_pkg::KEY_EMPTY;
    if (i == 0) begin : g_first
      assign prev_key = rmf_pkg::KEY_LOW;
      assign prev_gt  = 1'b0;
    end else begin : g_rest
      assign prev_key = keys[i-1];
      assign prev_gt  = gts[i-1];
    end

    rmf_sort_cell u_cell (
      .clk      (clk),
      .init     (init),
      .init_key (init_key),
      .insert   (insert),
      .new_key  (new_key),
      .prev_key (prev_key),
      .prev_gt  (prev_gt),
      .key      (keys[i]),
      .gt       (gts[i])
    );
  end

  // Pads center the data so the median sits at the middle cell, or for an even count at the middle pair.
  assign pair_sum = {1'b0, keys[MID-1].val} + {1'b0, keys[MID].val};
  assign median   = n_even ? pair_sum[8:1] : keys[MID].val;

endmodule

/* design/rgb_median_filter_clipped_window.sv */
// Streaming RGB median filter over a clipped square window: top level.
// Depends on rmf_pkg, rmf_line_store, rmf_sort_chain, rmf_sort_cell.
//
// Usage:
//  - Input words (operation, red_in, green_in, blue_in) arrive on in_valid /
//    in_ready in raster order; operation flush drains one pending output once
//    the frame is complete. Result words leave on out_valid / out_ready.
//  - Config is a plain write port (cfg_write, cfg_index, cfg_data); any write
//    to radius, width or height restarts the frame. Write only while idle.
//  - Outputs trail inputs by radius*width+radius pixels. frame_last marks the
//    bottom right output; after it the next pixel starts a new frame.
//  - Per output word the block passes through a setup state, a scan state that
//    reads the window positions in raster order (one line store read port, one
//    insert into the sort chain per cycle for each position inside the frame),
//    a drain state and a load state that fills the output register. A word
//    that causes no output leaves the block idle, ready for the next word.
//  - in_ready is high only in the idle state. The output register
//    holds a finished word while the receiver stalls; the next word is still
//    accepted and sorted, and only the load into the output register waits.
//  - Reset clears counters and the config to its defaults; the line store is
//    not cleared, since only pixels of the current frame are ever used.
module rgb_median_filter_clipped_window #(
  parameter int MAX_WIDTH  = rmf_pkg::DEF_MAX_WIDTH,
  parameter int MAX_RADIUS = rmf_pkg::DEF_MAX_RADIUS
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_write,
  input  logic [rmf_pkg::IDX_W-1:0]    cfg_index,
  input  logic [rmf_pkg::CFG_W-1:0]    cfg_data,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         operation,
  input  logic [7:0]                   red_in,
  input  logic [7:0]                   green_in,
  input  logic [7:0]                   blue_in,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [7:0]                   red_median,
  output logic [7:0]                   green_median,
  output logic [7:0]                   blue_median,
  output logic                         frame_last
);

  localparam int DEPTH = 2 * MAX_RADIUS * MAX_WIDTH + 2 * MAX_RADIUS + 1;
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = $clog2(MAX_WIDTH + 1);
  localparam int XW    = $clog2(MAX_WIDTH);
  localparam int HW    = rmf_pkg::HGT_W;
  localparam int TW    = CW + HW;
  localparam int CELLS = (2 * MAX_RADIUS + 1) * (2 * MAX_RADIUS + 1);
  localparam int NW    = $clog2(CELLS + 1);
  localparam int KW    = rmf_pkg::KOFF_W;

  typedef enum logic [2:0] {IDLE, SETUP, SCAN, DRAIN, FIN} state_t;

  state_t state;

  // config registers
  logic [1:0]              kernel_radius;
  logic [rmf_pkg::CFG_W-1:0] image_width;
  logic [rmf_pkg::CFG_W-1:0] image_height;

  // effective config
  logic [1:0]    er;
  logic [CW-1:0] ew;
  logic [HW-1:0] eh;
  logic [TW-1:0] total;
  logic [TW-1:0] lag;

  // frame position
  logic [TW-1:0] recv;
  logic [TW-1:0] sent;
  logic [XW-1:0] out_col;
  logic [HW-1:0] out_row;
  logic [AW-1:0] wptr;     // raster index of next input, mod DEPTH
  logic [AW-1:0] rptr;     // raster index of next output, mod DEPTH

  // window scan
  logic signed [KW-1:0] ky, kx;
  logic [AW-1:0]        rd_addr;
  logic                 ins_q;
  logic                 n_even;

  logic                 accept;
  logic                 cfg_hit;
  logic                 in_frame;
  logic                 out_free;
  logic                 is_last;

  // setup geometry
  logic [NW-1:0]        n_win;
  logic [NW-1:0]        pad_low;
  logic [AW-1:0]        start_addr;
  logic [AW-1:0]        row_addr;
  logic [AW-1:0]        next_addr;

  rmf_pkg::pixel_t      wr_px;
  rmf_pkg::pixel_t      rd_px;
  logic [7:0]           med_r, med_g, med_b;

  assign accept   = in_valid && in_ready;
  assign in_ready = (state == IDLE);
  assign out_free = !out_valid || out_ready;
  assign cfg_hit  = cfg_write && (cfg_index == rmf_pkg::REG_RADIUS ||
                                  cfg_index == rmf_pkg::REG_WIDTH  ||
                                  cfg_index == rmf_pkg::REG_HEIGHT);
  assign is_last  = (sent == total - TW'(1));

  always_comb begin
    er = (int'(kernel_radius) > MAX_RADIUS) ? 2'(MAX_RADIUS) : kernel_radius;
    if (image_width == '0) begin
      ew = CW'(1);
    end else if (int'(image_width) > MAX_WIDTH) begin
      ew = CW'(MAX_WIDTH);
    end else begin
      ew = CW'(image_width);
    end
    eh    = (image_height == '0) ? HW'(1) : HW'(image_height);
    total = TW'(ew) * TW'(eh);
    lag   = TW'(er) * TW'(ew) + TW'(er);
  end

  // Clipped window size, low pad count, first read address and scan address steps for the next output.
  always_comb begin
    int r, oy, ox, ylo, yhi, xlo, xhi, t;
    r   = int'(er);
    oy  = int'(out_row);
    ox  = int'(out_col);
    ylo = (oy - r < 0) ? 0 : oy - r;
    yhi = (oy + r > int'(eh) - 1) ? int'(eh) - 1 : oy + r;
    xlo = (ox - r < 0) ? 0 : ox - r;
    xhi = (ox + r > int'(ew) - 1) ? int'(ew) - 1 : ox + r;
    n_win   = NW'((yhi - ylo + 1) * (xhi - xlo + 1));
    pad_low = NW'((CELLS - int'(n_win)) / 2);
    t = int'(rptr) - int'(lag);
    if (t < 0) t = t + DEPTH;
    start_addr = AW'(t);
    t = int'(rd_addr) + int'(ew) - 2 * r;
    if (t < 0) begin
      t = t + DEPTH;
    end else if (t >= DEPTH) begin
      t = t - DEPTH;
    end
    row_addr  = AW'(t);
    next_addr = (int'(rd_addr) == DEPTH - 1) ? '0 : rd_addr + AW'(1);
  end

  always_comb begin
    int y, x;
    y = int'(out_row) + int'(ky);
    x = int'(out_col) + int'(kx);
    in_frame = (y >= 0) && (y < int'(eh)) && (x >= 0) && (x < int'(ew));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= IDLE;
      kernel_radius <= rmf_pkg::RADIUS_RST;
      image_width   <= rmf_pkg::WIDTH_RST;
      image_height  <= rmf_pkg::HEIGHT_RST;
      recv          <= '0;
      sent          <= '0;
      out_col       <= '0;
      out_row       <= '0;
      wptr          <= '0;
      rptr          <= '0;
      out_valid     <= 1'b0;
      ins_q         <= 1'b0;
    end else begin
      // in FIN the load below decides out_valid
      if (out_valid && out_ready && state != FIN) begin
        out_valid <= 1'b0;
      end
      ins_q <= (state == SCAN) && in_frame;

      if (cfg_write) begin
        unique case (cfg_index)
          rmf_pkg::REG_RADIUS: kernel_radius <= cfg_data[1:0];
          rmf_pkg::REG_WIDTH:  image_width   <= cfg_data;
          rmf_pkg::REG_HEIGHT: image_height  <= cfg_data;
          default: ;
        endcase
      end
      if (cfg_hit) begin
        recv    <= '0;
        sent    <= '0;
        out_col <= '0;
        out_row <= '0;
        wptr    <= '0;
        rptr    <= '0;
      end

      unique case (state)
        IDLE: begin
          if (accept) begin
            if (operation == rmf_pkg::OP_PIXEL) begin
              if (recv < total) begin
                recv <= recv + TW'(1);
                wptr <= (int'(wptr) == DEPTH - 1) ? '0 : wptr + AW'(1);
                if (recv + TW'(1) - sent > lag) begin
                  state <= SETUP;
                end
              end
            end else if (recv >= total && sent < total) begin
              state <= SETUP;
            end
          end
        end
        SETUP: begin
          ky      <= -KW'(signed'({1'b0, er}));
          kx      <= -KW'(signed'({1'b0, er}));
          rd_addr <= start_addr;
          n_even  <= !n_win[0];
          state   <= SCAN;
        end
        SCAN: begin
          if (kx == KW'(er)) begin
            kx      <= -KW'(signed'({1'b0, er}));
            ky      <= ky + KW'(1);
            rd_addr <= row_addr;
            if (ky == KW'(er)) begin
              state <= DRAIN;
            end
          end else begin
            kx      <= kx + KW'(1);
            rd_addr <= next_addr;
          end
        end
        DRAIN: begin
          state <= FIN;
        end
        FIN: begin
          if (out_free) begin
            out_valid    <= 1'b1;
            red_median   <= med_r;
            green_median <= med_g;
            blue_median  <= med_b;
            frame_last   <= is_last;
            if (is_last) begin
              recv    <= '0;
              sent    <= '0;
              out_col <= '0;
              out_row <= '0;
              wptr    <= '0;
              rptr    <= '0;
            end else begin
              sent <= sent + TW'(1);
              rptr <= (int'(rptr) == DEPTH - 1) ? '0 : rptr + AW'(1);
              if (int'(out_col) + 1 >= int'(ew)) begin
                out_col <= '0;
                out_row <= out_row + HW'(1);
              end else begin
                out_col <= out_col + XW'(1);
              end
            end
            state <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

  assign wr_px = '{red: red_in, green: green_in, blue: blue_in};

  rmf_line_store #(.DEPTH(DEPTH), .AW(AW)) u_store (
    .clk     (clk),
    .wr_en   (accept && operation == rmf_pkg::OP_PIXEL && recv < total),
    .wr_addr (wptr),
    .wr_data (wr_px),
    .rd_addr (rd_addr),
    .rd_data (rd_px)
  );

  rmf_sort_chain #(.CELLS(CELLS), .NW(NW)) u_sort_r (
    .clk (clk), .init (state == SETUP), .pad_low (pad_low), .insert (ins_q),
    .value (rd_px.red), .n_even (n_even), .median (med_r)
  );

  rmf_sort_chain #(.CELLS(CELLS), .NW(NW)) u_sort_g (
    .clk (clk), .init (state == SETUP), .pad_low (pad_low), .insert (ins_q),
    .value (rd_px.green), .n_even (n_even), .median (med_g)
  );

  rmf_sort_chain #(.CELLS(CELLS), .NW(NW)) u_sort_b (
    .clk (clk), .init (state == SETUP), .pad_low (pad_low), .insert (ins_q),
    .value (rd_px.blue), .n_even (n_even), .median (med_b)
  );

  // outputs never overtake inputs
  a_sent_le_recv: assert property (@(posedge clk) disable iff (rst) sent <= recv)
    else $error("output count passed input count");

  a_ptr_range: assert property (@(posedge clk) disable iff (rst)
    (int'(wptr) < DEPTH) && (int'(rptr) < DEPTH))
    else $error("ring pointer out of range");

  a_scan_addr: assert property (@(posedge clk) disable iff (rst)
    (state == SCAN) |-> (int'(rd_addr) < DEPTH))
    else $error("window read address out of range");

  a_no_insert_idle: assert property (@(posedge clk) disable iff (rst)
    (state == IDLE) |-> !ins_q)
    else $error("sort insert outside a window scan");

endmodule

/* bench/rgb_median_filter_clipped_window_tb.sv */
// Self-checking bench for the streaming RGB median filter (clipped window).
// Depends on rmf_pkg and rgb_median_filter_clipped_window; needs nothing else.
`timescale 1ns / 100ps

module rgb_median_filter_clipped_window_tb;

  localparam int MAXW        = rmf_pkg::DEF_MAX_WIDTH;
  localparam int MAXR        = rmf_pkg::DEF_MAX_RADIUS;
  localparam int IDX_W       = rmf_pkg::IDX_W;
  localparam int CFG_W       = rmf_pkg::CFG_W;
  // Ring of recent pixels, twice the worst-case lag plus one deep.
  localparam int STORE_DEPTH = 2 * MAXR * MAXW + 2 * MAXR + 1;
  localparam int WIN_MAX     = (2 * MAXR + 1) * (2 * MAXR + 1);
  localparam int IDLE_TAIL   = 80;     // > longest sort of one window
  localparam int STALL_LIMIT = 20000;  // cycles with no word moving

  typedef struct {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       last;
  } median_word_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             cfg_write = 1'b0;
  logic [IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_data = '0;
  logic             in_valid = 1'b0;
  logic             in_ready;
  logic             operation = rmf_pkg::OP_PIXEL;
  logic [7:0]       red_in = '0;
  logic [7:0]       green_in = '0;
  logic [7:0]       blue_in = '0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  logic [7:0]       red_median;
  logic [7:0]       green_median;
  logic [7:0]       blue_median;
  logic             frame_last;

  rgb_median_filter_clipped_window DUT (.*);

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // ---------------------------------------------------------------------
  // Shadow of the filter: config, counters and pixel ring.
  // ---------------------------------------------------------------------
  logic [1:0]       sh_radius;
  logic [CFG_W-1:0] sh_width;
  logic [CFG_W-1:0] sh_height;
  rmf_pkg::pixel_t  pixel_ring [STORE_DEPTH];
  int               in_col, in_row, out_col, out_row;

  median_word_t     median_queue [$];   // medians still owed by the DUT
  int               mismatches = 0;
  int               words_sent = 0;

  // Knobs shared between the stimulus and the receiver.
  int  gap_pct   = 0;   // chance the sender idles after a word
  int  stall_pct = 0;   // chance the receiver drops ready in a cycle
  bit  hold_go   = 1'b0;

  function automatic int win_w();
    if (sh_width == 0) return 1;
    if (sh_width > MAXW) return MAXW;
    return int'(sh_width);
  endfunction

  function automatic int win_h();
    return (sh_height == 0) ? 1 : int'(sh_height);
  endfunction

  function automatic bit frame_complete();
    return (in_row * win_w() + in_col) >= win_w() * win_h();
  endfunction

  // Median of n values; even count takes the floor mean of the middle pair.
  function automatic logic [7:0] chan_median(int vals[WIN_MAX], int n);
    int i, j, t;
    for (i = 1; i < n; i++) begin
      t = vals[i];
      j = i;
      while (j > 0 && vals[j-1] > t) begin
        vals[j] = vals[j-1];
        j--;
      end
      vals[j] = t;
    end
    if (n % 2 == 0) return 8'((vals[n/2-1] + vals[n/2]) / 2);
    return 8'(vals[n/2]);
  endfunction

  // Build the clipped window around the next output pixel and advance.
  function automatic median_word_t window_median();
    int w, h, r, x, y, n;
    int rv[WIN_MAX], gv[WIN_MAX], bv[WIN_MAX];
    rmf_pkg::pixel_t p;
    median_word_t m;
    w = win_w();
    h = win_h();
    r = int'(sh_radius);
    n = 0;
    for (y = out_row - r; y <= out_row + r; y++) begin
      for (x = out_col - r; x <= out_col + r; x++) begin
        if (y >= 0 && y < h && x >= 0 && x < w) begin
          p = pixel_ring[(y * w + x) % STORE_DEPTH];
          rv[n] = int'(p.red);
          gv[n] = int'(p.green);
          bv[n] = int'(p.blue);
          n++;
        end
      end
    end
    m.red   = chan_median(rv, n);
    m.green = chan_median(gv, n);
    m.blue  = chan_median(bv, n);
    m.last  = (out_row * w + out_col == w * h - 1);
    if (m.last) begin
      in_col = 0; in_row = 0; out_col = 0; out_row = 0;
    end else begin
      out_col++;
      if (out_col >= w) begin
        out_col = 0;
        out_row++;
      end
    end
    return m;
  endfunction

  // Apply one accepted word; queue the median it releases, if any.
  function automatic void filter_word(logic op, rmf_pkg::pixel_t p);
    int w, total, recv, sent, lag;
    w     = win_w();
    total = w * win_h();
    recv  = in_row * w + in_col;
    sent  = out_row * w + out_col;
    lag   = int'(sh_radius) * w + int'(sh_radius);
    if (op == rmf_pkg::OP_PIXEL) begin
      if (recv >= total) return;          // surplus pixel, dropped
      pixel_ring[recv % STORE_DEPTH] = p;
      in_col++;
      if (in_col >= w) begin
        in_col = 0;
        in_row++;
      end
      if (recv + 1 - sent > lag) median_queue.push_back(window_median());
    end else if (recv >= total && sent < total) begin
      median_queue.push_back(window_median());
    end
  endfunction

  // ---------------------------------------------------------------------
  // Receiver: random stalls plus an optional long hold-off.
  // ---------------------------------------------------------------------
  int hold_left = 0;
  always @(posedge clk) begin
    if (hold_go) begin
      hold_go = 1'b0;
      hold_left = 400;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Compare each delivered word against the oldest owed median.
  always @(posedge clk) begin
    median_word_t m;
    if (!rst && out_valid && out_ready) begin
      if (median_queue.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected word: r=%0d g=%0d b=%0d last=%0b",
                   red_median, green_median, blue_median, frame_last);
      end else begin
        m = median_queue.pop_front();
        if (m.red !== red_median || m.green !== green_median ||
            m.blue !== blue_median || m.last !== frame_last) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"mismatch: exp r=%0d g=%0d b=%0d last=%0b, ",
                      "got r=%0d g=%0d b=%0d last=%0b"},
                     m.red, m.green, m.blue, m.last,
                     red_median, green_median, blue_median, frame_last);
        end
      end
    end
  end

  // Watchdog: too long without any word moving on either side.
  int quiet = 0;
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet >= STALL_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // Sender helpers. All are entered and left just after a rising edge.
  // ---------------------------------------------------------------------
  task automatic send_word(logic op, logic [7:0] r, logic [7:0] g, logic [7:0] b);
    rmf_pkg::pixel_t p;
    p = '{red: r, green: g, blue: b};
    in_valid  <= 1'b1;
    operation <= op;
    red_in    <= r;
    green_in  <= g;
    blue_in   <= b;
    do @(posedge clk); while (!in_ready);
    filter_word(op, p);
    words_sent++;
    // valid stays up for a back-to-back word unless we idle here
    if ($urandom_range(99) < gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  task automatic send_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b);
    send_word(rmf_pkg::OP_PIXEL, r, g, b);
  endtask

  task automatic send_flush();
    send_word(rmf_pkg::OP_FLUSH, 8'($urandom), 8'($urandom), 8'($urandom));
  endtask

  // Wait until every owed median came out and the sorter is quiet.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (median_queue.size() != 0) @(posedge clk);
    repeat (IDLE_TAIL) @(posedge clk);
  endtask

  // Write pulse, and cfg_write is low again before the task returns, so back-to-back writes never collide.
  task automatic write_reg(logic [IDX_W-1:0] idx, int value);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= CFG_W'(value);
    @(posedge clk);
    cfg_write <= 1'b0;
    case (idx)
      rmf_pkg::REG_RADIUS: sh_radius = 2'(value);
      rmf_pkg::REG_WIDTH:  sh_width  = CFG_W'(value);
      rmf_pkg::REG_HEIGHT: sh_height = CFG_W'(value);
      default: ;
    endcase
    in_col = 0; in_row = 0; out_col = 0; out_row = 0;
    @(posedge clk);
  endtask

  task automatic set_frame(int radius, int w, int h);
    wait_idle();
    write_reg(rmf_pkg::REG_RADIUS, radius);
    write_reg(rmf_pkg::REG_WIDTH, w);
    write_reg(rmf_pkg::REG_HEIGHT, h);
  endtask

  // Random channel value with the extremes favored.
  function automatic logic [7:0] rand_chan();
    case ($urandom_range(7))
      0: return 8'd0;
      1: return 8'd255;
      default: return 8'($urandom);
    endcase
  endfunction

  // One frame with random content; noise_pct mixes in early flushes.
  task automatic run_frame(int noise_pct);
    while (!frame_complete() || in_row + in_col == 0) begin
      if ($urandom_range(99) < noise_pct) send_flush();
      send_pixel(rand_chan(), rand_chan(), rand_chan());
      if (in_row + in_col == 0 && median_queue.size() != 0 &&
          median_queue[$].last) break;
    end
    if (frame_complete() && $urandom_range(99) < 30)
      send_pixel(rand_chan(), rand_chan(), rand_chan());  // surplus, ignored
    while (frame_complete()) send_flush();
  endtask

  // ---------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------

  // 3x3 frame at radius 1: early flush, corner extremes, surplus, drain.
  task automatic test_borders();
    set_frame(1, 3, 3);
    send_flush();                        // frame not complete: no effect
    send_pixel(8'd0, 8'd255, 8'd0);
    send_pixel(8'd255, 8'd0, 8'd255);
    send_pixel(8'd0, 8'd0, 8'd0);
    send_pixel(8'd255, 8'd255, 8'd255);
    send_pixel(8'd1, 8'd128, 8'd254);
    send_pixel(8'd2, 8'd127, 8'd253);
    send_pixel(8'd255, 8'd255, 8'd0);
    send_pixel(8'd0, 8'd1, 8'd255);
    send_pixel(8'd170, 8'd85, 8'd15);
    send_pixel(8'd99, 8'd99, 8'd99);     // surplus pixel, dropped
    while (frame_complete()) send_flush();
    // frame end reset the counters: a second frame follows right away
    run_frame(0);
  endtask

  // Out-of-range register values fall back to the clipped sizes.
  task automatic test_clipped_regs();
    set_frame(0, 0, 0);                  // 1x1 frame
    send_pixel(8'd255, 8'd0, 8'd128);
    set_frame(3, 0, 0);                  // whole window clipped to one pixel
    send_pixel(8'd7, 8'd200, 8'd255);
    while (frame_complete()) send_flush();
    set_frame(2, 2, 0);
    run_frame(0);
    set_frame(0, 2047, 1);               // width above the maximum line width
    run_frame(0);
  endtask

  // Largest radius on a single column and on a single short line.
  task automatic test_extreme_sizes();
    set_frame(3, 1, 24);
    run_frame(0);
    set_frame(3, 24, 1);
    run_frame(0);
  endtask

  task automatic test_random_frames(int target);
    int stop_at;
    stop_at = words_sent + target;
    while (words_sent < stop_at) begin
      if ($urandom_range(3) != 0)
        set_frame($urandom_range(MAXR), $urandom_range(1, 12),
                  $urandom_range(1, 8));
      run_frame(5);
    end
  endtask

  // Receiver holds off for a long stretch while frames keep coming.
  task automatic test_backpressure();
    set_frame(1, 6, 6);
    @(posedge clk);
    hold_go = 1'b1;
    run_frame(0);
    run_frame(0);
  endtask

  initial begin
    sh_radius = rmf_pkg::RADIUS_RST;
    sh_width  = rmf_pkg::WIDTH_RST;
    sh_height = rmf_pkg::HEIGHT_RST;
    in_col = 0; in_row = 0; out_col = 0; out_row = 0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_borders();
    test_clipped_regs();
    test_extreme_sizes();

    gap_pct = 10; stall_pct = 56;
    test_random_frames(160);
    gap_pct = 56; stall_pct = 10;
    test_random_frames(160);
    gap_pct = 0; stall_pct = 0;
    test_random_frames(140);
    test_backpressure();

    wait_idle();
    if (mismatches == 0 && median_queue.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
